// ===== rtl/jsv_pkg.sv =====
// Package: shared types and constants of the JSON syntax validator.
`timescale 1ns / 1ps
`default_nettype none

package jsv_pkg;

    // Byte classes produced by the front end
    typedef enum logic [4:0] {
        CLS_WS,
        CLS_QUOTE,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_LBRACK,
        CLS_RBRACK,
        CLS_COMMA,
        CLS_COLON,
        CLS_BSLASH,
        CLS_DIGIT,
        CLS_MINUS,
        CLS_PLUS,
        CLS_DOT,
        CLS_EXP,
        CLS_LIT_T,
        CLS_LIT_F,
        CLS_LIT_N,
        CLS_OTHER
    } t_cls;

    // Parser modes of the back end
    typedef enum logic [4:0] {
        M_VALUE,
        M_OBJ_FIRST,
        M_ARR_FIRST,
        M_KEY,
        M_KSTR,
        M_KESC,
        M_COLON,
        M_VSTR,
        M_VESC,
        M_AFTER,
        M_LIT,
        M_NSIGN,
        M_NINT,
        M_NFRAC,
        M_NEXP0,
        M_NEXP1
    } t_mode;

    // Literal kinds
    typedef enum logic [1:0] {
        LIT_TRUE,
        LIT_FALSE,
        LIT_NULL
    } t_lit;

    // One classified word travelling from front to back
    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
        logic       last;
    } t_token;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

// ===== rtl/json_syntax_validator.sv =====
// Top level: streaming JSON syntax validator with a bounded nesting stack.
`timescale 1ns / 1ps
`default_nettype none

// Takes one document byte per cycle on i_data_byte with i_last_byte marking
// the final byte, and returns one verdict word (o_valid_res, o_depth_overflow)
// per document. Sustained rate is one byte per clock while verdicts are
// taken: the front classifies a byte in the accept cycle, a two-entry queue
// carries it to the back, and the back updates the pushdown parser. The
// nesting stack keeps its top entry in a register and the rest in a RAM of
// MAX_DEPTH one-bit entries whose registered read is prefetched one level
// below the top. A verdict is registered when the back takes the final byte
// and sits in an output register, so input stalls only when the queue fills
// behind an untaken verdict. No clearing pass is needed after reset.
module json_syntax_validator #(
    parameter int MAX_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_valid_res,
    output logic            o_depth_overflow
);

    logic            fq_valid, fq_ready;
    jsv_pkg::t_token fq_tok;
    logic            qb_valid, qb_ready;
    jsv_pkg::t_token qb_tok;

    // Classify incoming bytes
    jsv_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_tok_valid (fq_valid),
        .i_tok_ready (fq_ready),
        .o_tok       (fq_tok)
    );

    // Decouple front and back
    jsv_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_tok   (fq_tok),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_tok   (qb_tok)
    );

    // Parse and report
    jsv_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tok_valid      (qb_valid),
        .o_tok_ready      (qb_ready),
        .i_tok            (qb_tok),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_valid_res      (o_valid_res),
        .o_depth_overflow (o_depth_overflow)
    );

endmodule

`default_nettype wire

// ===== rtl/jsv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module jsv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/jsv_front.sv =====
// Front end: accepts document bytes and classifies each one into a token.
`timescale 1ns / 1ps
`default_nettype none

module jsv_front (
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    output logic               o_tok_valid,
    input  wire logic          i_tok_ready,
    output jsv_pkg::t_token    o_tok
);

    jsv_pkg::t_cls cls;

    // Classify the byte
    always_comb begin
        unique case (i_data_byte)
            8'h20, 8'h09, 8'h0A, 8'h0D: cls = jsv_pkg::CLS_WS;
            8'h22:                      cls = jsv_pkg::CLS_QUOTE;
            8'h7B:                      cls = jsv_pkg::CLS_LBRACE;
            8'h7D:                      cls = jsv_pkg::CLS_RBRACE;
            8'h5B:                      cls = jsv_pkg::CLS_LBRACK;
            8'h5D:                      cls = jsv_pkg::CLS_RBRACK;
            8'h2C:                      cls = jsv_pkg::CLS_COMMA;
            8'h3A:                      cls = jsv_pkg::CLS_COLON;
            8'h5C:                      cls = jsv_pkg::CLS_BSLASH;
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
            8'h35, 8'h36, 8'h37, 8'h38, 8'h39:
                                        cls = jsv_pkg::CLS_DIGIT;
            8'h2D:                      cls = jsv_pkg::CLS_MINUS;
            8'h2B:                      cls = jsv_pkg::CLS_PLUS;
            8'h2E:                      cls = jsv_pkg::CLS_DOT;
            8'h65, 8'h45:               cls = jsv_pkg::CLS_EXP;
            8'h74:                      cls = jsv_pkg::CLS_LIT_T;
            8'h66:                      cls = jsv_pkg::CLS_LIT_F;
            8'h6E:                      cls = jsv_pkg::CLS_LIT_N;
            default:                    cls = jsv_pkg::CLS_OTHER;
        endcase
    end

    // Hand the word to the queue
    always_comb begin
        o_tok_valid  = i_valid;
        o_ready      = i_tok_ready;
        o_tok.cls    = cls;
        o_tok.data   = i_data_byte;
        o_tok.last   = i_last_byte;
    end

endmodule

`default_nettype wire

// ===== rtl/jsv_queue.sv =====
// Short FIFO that decouples the classifying front from the parsing back.
`timescale 1ns / 1ps
`default_nettype none

module jsv_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_valid,
    output logic                 o_wr_ready,
    input  wire jsv_pkg::t_token i_wr_tok,
    output logic                 o_rd_valid,
    input  wire logic            i_rd_ready,
    output jsv_pkg::t_token      o_rd_tok
);

    localparam int CW = $clog2(jsv_pkg::QUEUE_DEPTH + 1);

    jsv_pkg::t_token              r_slot [jsv_pkg::QUEUE_DEPTH];
    logic [jsv_pkg::QUEUE_PW-1:0] r_wptr, n_wptr;
    logic [jsv_pkg::QUEUE_PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0]                r_count, n_count;
    logic                         wr_fire, rd_fire;

    // Handshakes
    always_comb begin
        o_wr_ready = (r_count != CW'(jsv_pkg::QUEUE_DEPTH));
        o_rd_valid = (r_count != '0);
        o_rd_tok   = r_slot[r_rptr];
        wr_fire    = i_wr_valid && o_wr_ready;
        rd_fire    = o_rd_valid && i_rd_ready;
    end

    // Advance pointers and count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_fire) begin
            n_wptr = (r_wptr == jsv_pkg::QUEUE_PW'(jsv_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : r_wptr + 1'b1;
        end
        if (rd_fire) begin
            n_rptr = (r_rptr == jsv_pkg::QUEUE_PW'(jsv_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : r_rptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_slot[r_wptr] <= i_wr_tok;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jsv_back.sv =====
// Back end: pushdown parser that consumes tokens and registers the verdict.
`timescale 1ns / 1ps
`default_nettype none

module jsv_back #(
    parameter int MAX_DEPTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tok_valid,
    output logic                 o_tok_ready,
    input  wire jsv_pkg::t_token i_tok,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic                 o_valid_res,
    output logic                 o_depth_overflow
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    jsv_pkg::t_mode r_mode, n_mode;
    jsv_pkg::t_lit  r_kind, n_kind;
    logic [2:0]     r_prog, n_prog;
    logic [LW-1:0]  r_level, n_level;
    logic           r_top, n_top;
    logic           r_err, n_err;
    logic           r_ovf, n_ovf;
    logic           r_out_valid, r_out_res, r_out_ovf;
    logic           r_byp_valid, r_byp_data;

    logic           fire;
    logic           st_value, st_after;
    logic           push, push_obj, pop;
    logic           below_kind;
    logic           done;
    logic [7:0]     lit_ch;
    logic [2:0]     lit_len;
    logic [LW-1:0]  level_m1, nlevel_m2;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic           ram_rdata;
    jsv_pkg::t_mode push_mode;

    assign fire        = i_tok_valid && o_tok_ready;
    assign o_tok_ready = !r_out_valid || i_ready;

    // Expected literal character and literal length
    always_comb begin
        lit_len = 3'd4;
        lit_ch  = 8'h00;
        unique case (r_kind)
            jsv_pkg::LIT_FALSE: begin
                lit_len = 3'd5;
                unique case (r_prog)
                    3'd0:    lit_ch = 8'h66;
                    3'd1:    lit_ch = 8'h61;
                    3'd2:    lit_ch = 8'h6C;
                    3'd3:    lit_ch = 8'h73;
                    3'd4:    lit_ch = 8'h65;
                    default: lit_ch = 8'h00;
                endcase
            end
            jsv_pkg::LIT_NULL: begin
                unique case (r_prog)
                    3'd0:    lit_ch = 8'h6E;
                    3'd1:    lit_ch = 8'h75;
                    3'd2:    lit_ch = 8'h6C;
                    3'd3:    lit_ch = 8'h6C;
                    default: lit_ch = 8'h00;
                endcase
            end
            default: begin
                unique case (r_prog)
                    3'd0:    lit_ch = 8'h74;
                    3'd1:    lit_ch = 8'h72;
                    3'd2:    lit_ch = 8'h75;
                    3'd3:    lit_ch = 8'h65;
                    default: lit_ch = 8'h00;
                endcase
            end
        endcase
    end

    // Entry below the top of stack, with bypass of last cycle's write
    assign below_kind = r_byp_valid ? r_byp_data : ram_rdata;
    assign level_m1   = r_level - LW'(1);

    // Next parser state
    always_comb begin
        n_mode    = r_mode;
        n_kind    = r_kind;
        n_prog    = r_prog;
        n_level   = r_level;
        n_top     = r_top;
        n_err     = r_err;
        n_ovf     = r_ovf;
        st_value  = 1'b0;
        st_after  = 1'b0;
        push      = 1'b0;
        push_obj  = 1'b0;
        pop       = 1'b0;
        push_mode = jsv_pkg::M_OBJ_FIRST;

        // Step the mode on the current word
        if (fire && !r_err) begin
            unique case (r_mode)
                jsv_pkg::M_VALUE: st_value = 1'b1;
                jsv_pkg::M_OBJ_FIRST: begin
                    priority case (i_tok.cls)
                        jsv_pkg::CLS_WS:     ;
                        jsv_pkg::CLS_RBRACE: pop = 1'b1;
                        jsv_pkg::CLS_QUOTE:  n_mode = jsv_pkg::M_KSTR;
                        default:             n_err = 1'b1;
                    endcase
                end
                jsv_pkg::M_ARR_FIRST: begin
                    priority case (i_tok.cls)
                        jsv_pkg::CLS_WS:     ;
                        jsv_pkg::CLS_RBRACK: pop = 1'b1;
                        default:             st_value = 1'b1;
                    endcase
                end
                jsv_pkg::M_KEY: begin
                    priority case (i_tok.cls)
                        jsv_pkg::CLS_WS:    ;
                        jsv_pkg::CLS_QUOTE: n_mode = jsv_pkg::M_KSTR;
                        default:            n_err = 1'b1;
                    endcase
                end
                jsv_pkg::M_KSTR: begin
                    if (i_tok.cls == jsv_pkg::CLS_BSLASH) begin
                        n_mode = jsv_pkg::M_KESC;
                    end else if (i_tok.cls == jsv_pkg::CLS_QUOTE) begin
                        n_mode = jsv_pkg::M_COLON;
                    end
                end
                jsv_pkg::M_KESC: n_mode = jsv_pkg::M_KSTR;
                jsv_pkg::M_COLON: begin
                    priority case (i_tok.cls)
                        jsv_pkg::CLS_WS:    ;
                        jsv_pkg::CLS_COLON: n_mode = jsv_pkg::M_VALUE;
                        default:            n_err = 1'b1;
                    endcase
                end
                jsv_pkg::M_VSTR: begin
                    if (i_tok.cls == jsv_pkg::CLS_BSLASH) begin
                        n_mode = jsv_pkg::M_VESC;
                    end else if (i_tok.cls == jsv_pkg::CLS_QUOTE) begin
                        n_mode = jsv_pkg::M_AFTER;
                    end
                end
                jsv_pkg::M_VESC: n_mode = jsv_pkg::M_VSTR;
                jsv_pkg::M_AFTER: st_after = 1'b1;
                jsv_pkg::M_LIT: begin
                    if (r_prog < lit_len && i_tok.data == lit_ch) begin
                        if (r_prog + 3'd1 >= lit_len) begin
                            n_prog = 3'd0;
                            n_mode = jsv_pkg::M_AFTER;
                        end else begin
                            n_prog = r_prog + 3'd1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                jsv_pkg::M_NSIGN: begin
                    if (i_tok.cls == jsv_pkg::CLS_DIGIT) begin
                        n_mode = jsv_pkg::M_NINT;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                jsv_pkg::M_NINT: begin
                    priority case (i_tok.cls)
                        jsv_pkg::CLS_DIGIT: ;
                        jsv_pkg::CLS_DOT:   n_mode = jsv_pkg::M_NFRAC;
                        jsv_pkg::CLS_EXP:   n_mode = jsv_pkg::M_NEXP0;
                        default: begin
                            n_mode   = jsv_pkg::M_AFTER;
                            st_after = 1'b1;
                        end
                    endcase
                end
                jsv_pkg::M_NFRAC: begin
                    priority case (i_tok.cls)
                        jsv_pkg::CLS_DIGIT: ;
                        jsv_pkg::CLS_EXP:   n_mode = jsv_pkg::M_NEXP0;
                        default: begin
                            n_mode   = jsv_pkg::M_AFTER;
                            st_after = 1'b1;
                        end
                    endcase
                end
                jsv_pkg::M_NEXP0: begin
                    priority case (i_tok.cls)
                        jsv_pkg::CLS_DIGIT, jsv_pkg::CLS_PLUS, jsv_pkg::CLS_MINUS:
                            n_mode = jsv_pkg::M_NEXP1;
                        default: begin
                            n_mode   = jsv_pkg::M_AFTER;
                            st_after = 1'b1;
                        end
                    endcase
                end
                jsv_pkg::M_NEXP1: begin
                    if (i_tok.cls != jsv_pkg::CLS_DIGIT) begin
                        n_mode   = jsv_pkg::M_AFTER;
                        st_after = 1'b1;
                    end
                end
                default: n_err = 1'b1;
            endcase

            // Start of a value
            if (st_value) begin
                priority case (i_tok.cls)
                    jsv_pkg::CLS_WS:     ;
                    jsv_pkg::CLS_QUOTE:  n_mode = jsv_pkg::M_VSTR;
                    jsv_pkg::CLS_LBRACE: begin
                        push      = 1'b1;
                        push_obj  = 1'b1;
                        push_mode = jsv_pkg::M_OBJ_FIRST;
                    end
                    jsv_pkg::CLS_LBRACK: begin
                        push      = 1'b1;
                        push_mode = jsv_pkg::M_ARR_FIRST;
                    end
                    jsv_pkg::CLS_LIT_T: begin
                        n_mode = jsv_pkg::M_LIT;
                        n_kind = jsv_pkg::LIT_TRUE;
                        n_prog = 3'd1;
                    end
                    jsv_pkg::CLS_LIT_F: begin
                        n_mode = jsv_pkg::M_LIT;
                        n_kind = jsv_pkg::LIT_FALSE;
                        n_prog = 3'd1;
                    end
                    jsv_pkg::CLS_LIT_N: begin
                        n_mode = jsv_pkg::M_LIT;
                        n_kind = jsv_pkg::LIT_NULL;
                        n_prog = 3'd1;
                    end
                    jsv_pkg::CLS_MINUS:  n_mode = jsv_pkg::M_NSIGN;
                    jsv_pkg::CLS_DIGIT:  n_mode = jsv_pkg::M_NINT;
                    default:             n_err = 1'b1;
                endcase
            end

            // Separator or close after a value
            if (st_after && i_tok.cls != jsv_pkg::CLS_WS) begin
                if (r_level == '0) begin
                    n_err = 1'b1;
                end else if (i_tok.cls == jsv_pkg::CLS_COMMA) begin
                    n_mode = r_top ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
                end else if ((i_tok.cls == jsv_pkg::CLS_RBRACE && r_top) ||
                             (i_tok.cls == jsv_pkg::CLS_RBRACK && !r_top)) begin
                    pop = 1'b1;
                end else begin
                    n_err = 1'b1;
                end
            end

            // Push: refuse beyond the stack depth
            if (push) begin
                if (r_level >= LW'(MAX_DEPTH)) begin
                    n_ovf = 1'b1;
                    n_err = 1'b1;
                end else begin
                    n_top   = push_obj;
                    n_level = r_level + LW'(1);
                    n_mode  = push_mode;
                end
            end

            // Pop: the entry below becomes the top
            if (pop) begin
                n_level = level_m1;
                n_top   = below_kind;
                n_mode  = jsv_pkg::M_AFTER;
            end
        end

        // Verdict on the final byte, taken from the updated state
        done = (n_mode == jsv_pkg::M_AFTER) || (n_mode == jsv_pkg::M_NINT) ||
               (n_mode == jsv_pkg::M_NFRAC) || (n_mode == jsv_pkg::M_NEXP0) ||
               (n_mode == jsv_pkg::M_NEXP1);
    end

    // Stack RAM: the old top spills on a push, the next lower entry is prefetched
    assign ram_we    = fire && push && !r_err && (r_level < LW'(MAX_DEPTH)) &&
                       (r_level != '0);
    assign ram_waddr = level_m1[AW-1:0];
    assign nlevel_m2 = n_level - LW'(2);
    assign ram_raddr = nlevel_m2[AW-1:0];

    jsv_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_top),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Hold a write that lands on the address being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
            r_byp_data  <= 1'b0;
        end else begin
            r_byp_valid <= ram_we && (ram_waddr == ram_raddr);
            r_byp_data  <= r_top;
        end
    end

    // Parser state register, back to reset state after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_tok.last)) begin
            r_mode  <= jsv_pkg::M_VALUE;
            r_kind  <= jsv_pkg::LIT_TRUE;
            r_prog  <= 3'd0;
            r_level <= '0;
            r_top   <= 1'b0;
            r_err   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_kind  <= n_kind;
            r_prog  <= n_prog;
            r_level <= n_level;
            r_top   <= n_top;
            r_err   <= n_err;
            r_ovf   <= n_ovf;
        end
    end

    // Output register for the verdict word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_res   <= 1'b0;
            r_out_ovf   <= 1'b0;
        end else if (fire && i_tok.last) begin
            r_out_valid <= 1'b1;
            r_out_res   <= !n_err && (n_level == '0) && done;
            r_out_ovf   <= n_ovf;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_valid_res      = r_out_res;
    assign o_depth_overflow = r_out_ovf;

endmodule

`default_nettype wire
